// File: rtl/core/sag_pkg.sv
// ----------------------------------------------------------------------------
// sag_pkg: shared types and constants
// Payload structs, controller commands, datapath status and state encoding
// for the auto-ranging scope extent and gridline block.
// ----------------------------------------------------------------------------
package sag_pkg;

  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] CFG_OUTER_LOW  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_OUTER_HIGH = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_INNER_LOW  = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_INNER_HIGH = 2'd3;

  localparam logic [2:0] GRID_PERIOD = 3'd5;
  localparam int NARROW_SPAN = 33;
  localparam int NARROW_HALF = 66;

  typedef struct packed {
    logic               command;
    logic signed [31:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [31:0] extent_low;
    logic signed [31:0] extent_high;
    logic [3:0]         line_index;
    logic signed [31:0] line_value;
    logic               line_valid;
    logic               last;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXT_INIT,
    S_EXT_RD,
    S_EXT_UPD,
    S_EXT_FIN,
    S_GRID,
    S_GR_CLR,
    S_GR_RD,
    S_GR_MUL,
    S_GR_DPRE,
    S_GR_DSTEP,
    S_GR_ARD,
    S_GR_ACC,
    S_AV_RD,
    S_AV_GO,
    S_AV_WAIT,
    S_AV_WR,
    S_CH_INIT,
    S_CH_RD,
    S_CH_EVAL,
    S_CH_END,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic clr_hist;
    logic add;
    logic walk_init;
    logic walk_step;
    logic ext_init;
    logic ext_upd;
    logic ext_fin;
    logic gr_lines;
    logic bin_clr;
    logic gr_mul;
    logic gr_dpre;
    logic gr_dstep;
    logic sel_bin;
    logic gr_acc;
    logic av_start;
    logic av_wr;
    logic ch_init;
    logic ch_eval;
    logic ch_commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic held_last;
    logic bin_last;
    logic dstep_last;
    logic div_busy;
    logic best_valid;
    logic gc_next_full;
    logic span_zero;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

// File: rtl/core/sag_div.sv
// ----------------------------------------------------------------------------
// sag_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sag_div #(
  parameter int unsigned NW = 42,
  parameter int unsigned DW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [NW-1:0] quotient_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dv_q, dv_d;
  logic [DW:0]   remw;
  logic          ge;

  always_comb begin
    remw   = {rem_q, quo_q[NW-1]};
    ge     = remw >= {1'b0, dv_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dv_d   = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? DW'(remw - {1'b0, dv_q}) : remw[DW-1:0];
      quo_d  = {quo_q[NW-2:0], ge};
      cnt_d  = cnt_q - CW'(1);
      busy_d = cnt_q != CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/core/sag_dp.sv
// ----------------------------------------------------------------------------
// sag_dp: extent and gridline datapath
// History ring, extent walk, histogram binning, bin averaging, line choice
// and the output register.
// ----------------------------------------------------------------------------
module sag_dp #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned LINES = 8,
  parameter int unsigned BINS  = 50
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sag_pkg::cmd_t              cmd_i,
  output sag_pkg::sts_t              sts_o,
  input  sag_pkg::in_t               in_data_i,
  input  logic                       cfg_we_i,
  input  logic [sag_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [31:0]                cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output sag_pkg::out_t              out_data_o
);

  localparam int AW  = $clog2(DEPTH);
  localparam int HW  = $clog2(DEPTH + 1);
  localparam int LW  = $clog2(LINES + 1);
  localparam int KW  = $clog2(LINES);
  localparam int BW  = $clog2(BINS);
  localparam int SW  = 32 + HW;
  localparam int MW  = 40;
  localparam int RW  = 41;
  localparam int DSW = $clog2(BW + 1);
  localparam int THR = (DEPTH / (LINES - 2)) / 4;
  localparam logic signed [MW-1:0] BM1 = MW'(BINS - 1);

  // config
  logic signed [31:0] olow_q, ohigh_q, ilow_q, ihigh_q;

  // history and walk
  logic signed [31:0] ring_mem [DEPTH];
  logic signed [31:0] ring_rd_q;
  logic [AW-1:0]      wp_q, ptr_q, wp_inc, ptr_dec;
  logic [HW-1:0]      held_q, idx_q;

  // extent
  logic signed [31:0] cur_low_q, cur_high_q, lo_q, hi_q, lo_upd, hi_upd;
  logic signed [31:0] fin_low, fin_high;
  logic signed [33:0] d34, ml, mh;
  logic [33:0]        a34;
  logic signed [32:0] s33, mid, spn;
  logic [32:0]        span_mag;

  // binning
  logic signed [31:0] v_q;
  logic signed [32:0] diff33;
  logic signed [MW-1:0] n_q;
  logic [MW-1:0]      n_mag;
  logic [RW-1:0]      rem_q, sh;
  logic [BW-1:0]      quo_q, bin_b, bi_q, bin_addr;
  logic [DSW-1:0]     dstep_q;
  logic               neg_q, sat_q;

  // bin storage
  logic [HW-1:0]        cnt_mem [BINS];
  logic signed [SW-1:0] sum_mem [BINS];
  logic signed [31:0]   avg_mem [BINS];
  logic [HW-1:0]        cnt_rd_q;
  logic signed [SW-1:0] sum_rd_q;
  logic signed [31:0]   avg_rd_q;

  // averaging
  logic [SW-1:0]        sum_mag, div_q;
  logic signed [SW-1:0] avg_full;
  logic signed [31:0]   avg_val;
  logic                 div_busy;

  // line choice
  logic signed [31:0] gv_q [LINES];
  logic [LW-1:0]      gc_q, k_q, n_lines;
  logic               bv_q;
  logic [BW-1:0]      best_q;
  logic [HW-1:0]      best_cnt_q;
  logic signed [31:0] best_avg_q;
  logic               uniq, cand;
  logic signed [32:0] dj [LINES];
  logic [32:0]        mj [LINES];

  // output
  sag_pkg::out_t out_q, out_d;
  logic          out_valid_q;

  assign wp_inc  = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
  assign ptr_dec = (ptr_q == '0) ? AW'(DEPTH - 1) : ptr_q - AW'(1);

  always_comb begin
    lo_upd = lo_q;
    hi_upd = hi_q;
    if (ring_rd_q < lo_q) begin
      lo_upd = (ring_rd_q < olow_q) ? olow_q : ring_rd_q;
    end
    if (ring_rd_q > hi_q) begin
      hi_upd = (ring_rd_q > ohigh_q) ? ohigh_q : ring_rd_q;
    end
  end

  always_comb begin
    d34      = 34'(hi_q) - 34'(lo_q);
    a34      = d34[33] ? 34'(-d34) : d34;
    s33      = 33'(lo_q) + 33'(hi_q);
    mid      = s33 >>> 1;
    ml       = 34'(mid) - 34'(sag_pkg::NARROW_HALF);
    mh       = 34'(mid) + 34'(sag_pkg::NARROW_HALF);
    fin_low  = lo_q;
    fin_high = hi_q;
    if (a34 < 34'(sag_pkg::NARROW_SPAN)) begin
      fin_low  = (ml < 34'(olow_q)) ? olow_q : ml[31:0];
      fin_high = (mh > 34'(ohigh_q)) ? ohigh_q : mh[31:0];
    end
  end

  assign spn      = 33'(cur_high_q) - 33'(cur_low_q);
  assign span_mag = spn[32] ? 33'(-spn) : spn;
  assign diff33   = 33'(ring_rd_q) - 33'(cur_low_q);
  assign n_mag    = n_q[MW-1] ? MW'(-n_q) : n_q;
  assign sh       = RW'(span_mag) << (dstep_q - DSW'(1));

  always_comb begin
    if (neg_q) begin
      bin_b = '0;
    end else if (sat_q || quo_q > BW'(BINS - 1)) begin
      bin_b = BW'(BINS - 1);
    end else begin
      bin_b = quo_q;
    end
  end

  assign bin_addr = cmd_i.sel_bin ? bin_b : bi_q;

  assign sum_mag  = sum_rd_q[SW-1] ? SW'(-sum_rd_q) : sum_rd_q;
  assign avg_full = sum_rd_q[SW-1] ? -$signed(div_q) : $signed(div_q);
  assign avg_val  = (cnt_rd_q == '0) ? 32'sd0 : avg_full[31:0];

  sag_div #(
    .NW(SW),
    .DW(HW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.av_start),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_rd_q),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  always_comb begin
    uniq = 1'b1;
    for (int j = 0; j < LINES; j++) begin
      dj[j] = 33'(avg_rd_q) - 33'(gv_q[j]);
      mj[j] = dj[j][32] ? 33'(-dj[j]) : dj[j];
      if (LW'(j) < gc_q && !spn[32] && ({mj[j], 3'b000} < 36'(spn))) begin
        uniq = 1'b0;
      end
    end
    cand = (!bv_q || cnt_rd_q > best_cnt_q) && (cnt_rd_q > HW'(THR)) && uniq;
  end

  assign n_lines = (gc_q == '0) ? LW'(1) : gc_q;

  always_comb begin
    out_d.extent_low  = cur_low_q;
    out_d.extent_high = cur_high_q;
    out_d.line_valid  = gc_q != '0;
    out_d.line_index  = (gc_q != '0) ? 4'(k_q) : 4'd0;
    out_d.line_value  = (gc_q != '0) ? gv_q[k_q[KW-1:0]] : 32'sd0;
    out_d.last        = (k_q + LW'(1)) == n_lines;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      olow_q      <= '0;
      ohigh_q     <= '0;
      ilow_q      <= '0;
      ihigh_q     <= '0;
      wp_q        <= '0;
      held_q      <= '0;
      ptr_q       <= '0;
      idx_q       <= '0;
      cur_low_q   <= '0;
      cur_high_q  <= '0;
      gc_q        <= '0;
      k_q         <= '0;
      bi_q        <= '0;
      dstep_q     <= '0;
      bv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LINES; i++) begin
        gv_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sag_pkg::CFG_OUTER_LOW:  olow_q  <= cfg_data_i;
          sag_pkg::CFG_OUTER_HIGH: ohigh_q <= cfg_data_i;
          sag_pkg::CFG_INNER_LOW:  ilow_q  <= cfg_data_i;
          sag_pkg::CFG_INNER_HIGH: ihigh_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_hist) begin
        wp_q       <= '0;
        held_q     <= '0;
        cur_low_q  <= ilow_q;
        cur_high_q <= ihigh_q;
      end
      if (cmd_i.add) begin
        wp_q <= wp_inc;
        if (held_q != HW'(DEPTH)) begin
          held_q <= held_q + HW'(1);
        end
      end
      if (cmd_i.walk_init) begin
        ptr_q <= wp_q;
        idx_q <= '0;
      end
      if (cmd_i.walk_step) begin
        ptr_q <= ptr_dec;
        idx_q <= idx_q + HW'(1);
      end
      if (cmd_i.ext_fin) begin
        cur_low_q  <= fin_low;
        cur_high_q <= fin_high;
      end
      if (cmd_i.gr_lines) begin
        gc_q    <= LW'(2);
        gv_q[0] <= cur_low_q;
        gv_q[1] <= cur_high_q;
        bi_q    <= '0;
      end
      if (cmd_i.bin_clr || cmd_i.av_wr || cmd_i.ch_eval) begin
        bi_q <= (bi_q == BW'(BINS - 1)) ? '0 : bi_q + BW'(1);
      end
      if (cmd_i.gr_dpre) begin
        dstep_q <= DSW'(BW);
      end
      if (cmd_i.gr_dstep) begin
        dstep_q <= dstep_q - DSW'(1);
      end
      if (cmd_i.ch_init) begin
        bv_q <= 1'b0;
        bi_q <= '0;
      end
      if (cmd_i.ch_eval && cand) begin
        bv_q <= 1'b1;
      end
      if (cmd_i.ch_commit) begin
        gv_q[gc_q[KW-1:0]] <= best_avg_q;
        gc_q               <= gc_q + LW'(1);
      end
      if (cmd_i.emit) begin
        k_q         <= out_d.last ? '0 : k_q + LW'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    ring_rd_q <= ring_mem[ptr_q];
    if (cmd_i.add) begin
      ring_mem[wp_inc] <= in_data_i.sample;
    end
    if (cmd_i.ext_init) begin
      lo_q <= ilow_q;
      hi_q <= ihigh_q;
    end
    if (cmd_i.ext_upd) begin
      lo_q <= lo_upd;
      hi_q <= hi_upd;
    end
    if (cmd_i.gr_mul) begin
      n_q <= MW'(diff33) * BM1;
      v_q <= ring_rd_q;
    end
    if (cmd_i.gr_dpre) begin
      rem_q <= RW'(n_mag);
      quo_q <= '0;
      sat_q <= RW'(n_mag) >= (RW'(span_mag) << BW);
      neg_q <= (n_q[MW-1] ^ spn[32]) && (n_q != '0);
    end
    if (cmd_i.gr_dstep && rem_q >= sh) begin
      rem_q                          <= rem_q - sh;
      quo_q[dstep_q - DSW'(1)] <= 1'b1;
    end
    if (cmd_i.ch_eval && cand) begin
      best_q     <= bi_q;
      best_cnt_q <= cnt_rd_q;
      best_avg_q <= avg_rd_q;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  // bin storage
  always_ff @(posedge clk_i) begin
    cnt_rd_q <= cnt_mem[bin_addr];
    sum_rd_q <= sum_mem[bin_addr];
    avg_rd_q <= avg_mem[bin_addr];
    if (cmd_i.bin_clr) begin
      cnt_mem[bi_q] <= '0;
      sum_mem[bi_q] <= '0;
    end
    if (cmd_i.gr_acc) begin
      cnt_mem[bin_b] <= cnt_rd_q + HW'(1);
      sum_mem[bin_b] <= sum_rd_q + SW'(v_q);
    end
    if (cmd_i.ch_commit) begin
      cnt_mem[best_q] <= '0;
    end
    if (cmd_i.av_wr) begin
      avg_mem[bi_q] <= avg_val;
    end
  end

  assign sts_o.held_last    = (idx_q + HW'(1)) == held_q;
  assign sts_o.bin_last     = bi_q == BW'(BINS - 1);
  assign sts_o.dstep_last   = dstep_q == DSW'(1);
  assign sts_o.div_busy     = div_busy;
  assign sts_o.best_valid   = bv_q;
  assign sts_o.gc_next_full = (gc_q + LW'(1)) == LW'(LINES);
  assign sts_o.span_zero    = cur_low_q == cur_high_q;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;
  assign sts_o.emit_last    = out_d.last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HW'(DEPTH))
    else $error("held count beyond history depth");
  a_gc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gc_q <= LW'(LINES))
    else $error("gridline count beyond limit");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_hist |=> held_q == '0 && wp_q == '0)
    else $error("clear did not empty history");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");
`endif

endmodule

// File: rtl/core/sag_ctrl.sv
// ----------------------------------------------------------------------------
// sag_ctrl: sequencing state machine
// Walks inputs through extent rebuild, histogram, averaging, line
// choice and result emission, each rebuild only when its period counter is due; holds those counters.
// ----------------------------------------------------------------------------
module sag_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_cmd_i,
  output logic          in_ready_o,
  output sag_pkg::cmd_t cmd_o,
  input  sag_pkg::sts_t sts_i
);

  sag_pkg::state_e state_q, state_d;
  logic            ext_wait_q, ext_wait_d;
  logic [2:0]      grid_wait_q, grid_wait_d;

  // next state
  always_comb begin
    state_d     = state_q;
    ext_wait_d  = ext_wait_q;
    grid_wait_d = grid_wait_q;
    case (state_q)
      sag_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i) begin
            state_d = sag_pkg::S_EMIT;
          end else if (!ext_wait_q) begin
            ext_wait_d = 1'b1;
            state_d    = sag_pkg::S_EXT_INIT;
          end else begin
            ext_wait_d = 1'b0;
            state_d    = sag_pkg::S_GRID;
          end
        end
      end
      sag_pkg::S_EXT_INIT: state_d = sag_pkg::S_EXT_RD;
      sag_pkg::S_EXT_RD:   state_d = sag_pkg::S_EXT_UPD;
      sag_pkg::S_EXT_UPD: begin
        state_d = sts_i.held_last ? sag_pkg::S_EXT_FIN : sag_pkg::S_EXT_RD;
      end
      sag_pkg::S_EXT_FIN:  state_d = sag_pkg::S_GRID;
      sag_pkg::S_GRID: begin
        if (grid_wait_q != 3'd0) begin
          grid_wait_d = grid_wait_q - 3'd1;
          state_d     = sag_pkg::S_EMIT;
        end else begin
          grid_wait_d = sag_pkg::GRID_PERIOD;
          state_d     = sts_i.span_zero ? sag_pkg::S_EMIT : sag_pkg::S_GR_CLR;
        end
      end
      sag_pkg::S_GR_CLR: begin
        state_d = sts_i.bin_last ? sag_pkg::S_GR_RD : sag_pkg::S_GR_CLR;
      end
      sag_pkg::S_GR_RD:   state_d = sag_pkg::S_GR_MUL;
      sag_pkg::S_GR_MUL:  state_d = sag_pkg::S_GR_DPRE;
      sag_pkg::S_GR_DPRE: state_d = sag_pkg::S_GR_DSTEP;
      sag_pkg::S_GR_DSTEP: begin
        state_d = sts_i.dstep_last ? sag_pkg::S_GR_ARD : sag_pkg::S_GR_DSTEP;
      end
      sag_pkg::S_GR_ARD:  state_d = sag_pkg::S_GR_ACC;
      sag_pkg::S_GR_ACC: begin
        state_d = sts_i.held_last ? sag_pkg::S_AV_RD : sag_pkg::S_GR_RD;
      end
      sag_pkg::S_AV_RD:   state_d = sag_pkg::S_AV_GO;
      sag_pkg::S_AV_GO:   state_d = sag_pkg::S_AV_WAIT;
      sag_pkg::S_AV_WAIT: begin
        state_d = sts_i.div_busy ? sag_pkg::S_AV_WAIT : sag_pkg::S_AV_WR;
      end
      sag_pkg::S_AV_WR: begin
        state_d = sts_i.bin_last ? sag_pkg::S_CH_INIT : sag_pkg::S_AV_RD;
      end
      sag_pkg::S_CH_INIT: state_d = sag_pkg::S_CH_RD;
      sag_pkg::S_CH_RD:   state_d = sag_pkg::S_CH_EVAL;
      sag_pkg::S_CH_EVAL: begin
        state_d = sts_i.bin_last ? sag_pkg::S_CH_END : sag_pkg::S_CH_RD;
      end
      sag_pkg::S_CH_END: begin
        if (sts_i.best_valid && !sts_i.gc_next_full) begin
          state_d = sag_pkg::S_CH_INIT;
        end else begin
          state_d = sag_pkg::S_EMIT;
        end
      end
      sag_pkg::S_EMIT: begin
        if (sts_i.out_free && sts_i.emit_last) begin
          state_d = sag_pkg::S_IDLE;
        end
      end
      default: state_d = sag_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sag_pkg::S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.clr_hist = in_valid_i && in_cmd_i;
        cmd_o.add      = in_valid_i && !in_cmd_i;
      end
      sag_pkg::S_EXT_INIT: begin
        cmd_o.ext_init  = 1'b1;
        cmd_o.walk_init = 1'b1;
      end
      sag_pkg::S_EXT_UPD: begin
        cmd_o.ext_upd   = 1'b1;
        cmd_o.walk_step = 1'b1;
      end
      sag_pkg::S_EXT_FIN: cmd_o.ext_fin = 1'b1;
      sag_pkg::S_GRID: begin
        if (grid_wait_q == 3'd0 && !sts_i.span_zero) begin
          cmd_o.gr_lines  = 1'b1;
          cmd_o.walk_init = 1'b1;
        end
      end
      sag_pkg::S_GR_CLR:   cmd_o.bin_clr  = 1'b1;
      sag_pkg::S_GR_MUL:   cmd_o.gr_mul   = 1'b1;
      sag_pkg::S_GR_DPRE:  cmd_o.gr_dpre  = 1'b1;
      sag_pkg::S_GR_DSTEP: cmd_o.gr_dstep = 1'b1;
      sag_pkg::S_GR_ARD:   cmd_o.sel_bin  = 1'b1;
      sag_pkg::S_GR_ACC: begin
        cmd_o.gr_acc    = 1'b1;
        cmd_o.walk_step = 1'b1;
      end
      sag_pkg::S_AV_GO:   cmd_o.av_start = 1'b1;
      sag_pkg::S_AV_WR:   cmd_o.av_wr    = 1'b1;
      sag_pkg::S_CH_INIT: cmd_o.ch_init  = 1'b1;
      sag_pkg::S_CH_EVAL: cmd_o.ch_eval  = 1'b1;
      sag_pkg::S_CH_END:  cmd_o.ch_commit = sts_i.best_valid;
      sag_pkg::S_EMIT:    cmd_o.emit     = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sag_pkg::S_IDLE;
      ext_wait_q  <= 1'b0;
      grid_wait_q <= 3'd0;
    end else begin
      state_q     <= state_d;
      ext_wait_q  <= ext_wait_d;
      grid_wait_q <= grid_wait_d;
    end
  end

endmodule

// File: rtl/core/scope_autorange_gridlines.sv
// ----------------------------------------------------------------------------
// scope_autorange_gridlines: auto-ranging scope extent with gridlines
// One item at a time; a clear or add is followed by emission of its results.
// Extent rebuild reads each held history entry once and updates the extent.
// Gridline rebuild clears the bins, bins each held entry, averages every bin
// and then scans the bins once for each further gridline.
// Async active-low reset clears config, extent, counters and gridlines; no sweep.
// ----------------------------------------------------------------------------
module scope_autorange_gridlines #(
  parameter int unsigned HISTORY_DEPTH  = 128,
  parameter int unsigned GRID_LINES     = 8,
  parameter int unsigned HISTOGRAM_BINS = 50
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sag_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output sag_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [sag_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [31:0]                cfg_data_i
);

  sag_pkg::cmd_t cmd;
  sag_pkg::sts_t sts;

  sag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.command),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  sag_dp #(
    .DEPTH (HISTORY_DEPTH),
    .LINES (GRID_LINES),
    .BINS  (HISTOGRAM_BINS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
